/* hdl/asq_pkg.sv */
// ============================================================================
// asq_pkg
// Shared types and constants for the angle scan sequencer.
// ============================================================================
`default_nettype none

package asq_pkg;

  // Field and register widths.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam int ANG_CFG_W = 10;
  localparam int STEP_W    = 8;
  localparam int DWELL_W   = 12;
  localparam int RB_W      = 16;
  localparam int SP_W      = 14;
  localparam int ANGLE_W   = 8;
  localparam int EV_W      = 3;
  localparam int POLL_W    = 7;

  // Datapath widths: angle difference, increment, its magnitude, running angle.
  localparam int DIFF_W = ANG_CFG_W + 1;
  localparam int INC_W  = ANG_CFG_W + 1;
  localparam int MAG_W  = ANG_CFG_W;
  localparam int ACC_W  = 20;

  // Legal angle window upper bound in degrees.
  localparam int ANGLE_MAX = 180;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_SECONDS = 2'd3;

  // Configuration reset values.
  localparam logic [ANG_CFG_W-1:0] RST_START_ANGLE   = 10'd0;
  localparam logic [ANG_CFG_W-1:0] RST_END_ANGLE     = 10'd180;
  localparam logic [STEP_W-1:0]    RST_STEP_COUNT    = 8'd19;
  localparam logic [DWELL_W-1:0]   RST_DWELL_SECONDS = 12'd50;

  // Event codes reported with a result.
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_DONE    = 3'd1;
  localparam logic [EV_W-1:0] EV_ABORT   = 3'd2;
  localparam logic [EV_W-1:0] EV_RANGE   = 3'd3;
  localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd4;

  // Scan phase.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_POLL   = 2'd2,
    PH_DWELL  = 2'd3
  } phase_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DEC,
    DP_DIV,
    DP_INIT,
    DP_SET_TARGET,
    DP_ISSUE,
    DP_DWELL,
    DP_POLL,
    DP_NEXT,
    DP_FINISH,
    DP_DONE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [EV_W-1:0] ev;
  } dp_cmd_t;

  typedef struct packed {
    logic   start;
    logic   abort;
    phase_t phase;
    logic   tick_le1;
    logic   range_bad;
    logic   rb_match;
    logic   poll_max;
    logic   step_last;
    logic   div_done;
    logic   out_busy;
  } dp_status_t;

  // One timer tick.
  typedef struct packed {
    logic            start_req;
    logic            abort_req;
    logic [RB_W-1:0] readback;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic               clean_flag;
    logic               set_strobe;
    logic [SP_W-1:0]    setpoint;
    logic               angle_mark;
    logic [ANGLE_W-1:0] angle;
    logic               busy_res;
    logic [EV_W-1:0]    event_res;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/angle_scan_sequencer.sv */
// ============================================================================
// angle_scan_sequencer
// Tick-driven scan of an actuator over a list of angles.
// ============================================================================
// Usage:
//   Each transfer on the in_ channel is one timer tick with a start request,
//   an abort request and the actuator readback. Each tick yields exactly one
//   transfer on the out_ channel with the clean flag, setpoint strobe,
//   setpoint, angle mark, angle, busy flag and event code.
//   The cfg_ port writes start angle, end angle, step count and dwell time;
//   write it only while the sequencer is idle between ticks.
//   Timing: a controller steps the datapath through a tick one operation per
//   cycle, holding while the divider runs or the result is stalled. An
//   ordinary tick passes the load, decode and emit states to the result
//   register; a tick that ends a dwell or issues a setpoint passes further
//   states. The start tick runs the serial increment divider, one quotient
//   bit per cycle. The next tick is accepted the cycle after a result loads.
//   Reset: synchronous; the configuration returns to its defaults, the scan
//   goes idle, and in_stall is high for one cycle after reset is released.
//   A stalled result holds the output register; the controller then waits
//   before loading the next result, and the input stays stalled meanwhile.
// ============================================================================
`default_nettype none

module angle_scan_sequencer #(
  parameter int TICKS_PER_SECOND = 72,
  parameter int SETTLE_TICKS     = 12,
  parameter int POLL_TICKS       = 144,
  parameter int MAX_POLLS        = 120,
  parameter int SETPOINT_SCALE   = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [asq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  asq_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output asq_pkg::out_item_t            out_data
);
  import asq_pkg::*;

  // Tick counter must hold the longest dwell, settle or poll interval.
  localparam int DWELL_MAX  = ((1 << DWELL_W) - 1) * TICKS_PER_SECOND;
  localparam int WAIT_MAX   = (SETTLE_TICKS > POLL_TICKS) ? SETTLE_TICKS : POLL_TICKS;
  localparam int TICK_MAX   = (DWELL_MAX > WAIT_MAX) ? DWELL_MAX : WAIT_MAX;
  localparam int TICK_W     = $clog2(TICK_MAX + 1);

  dp_cmd_t    cmd;
  dp_status_t status;

  asq_ctrl #(
    .SETTLE_TICKS (SETTLE_TICKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  asq_dp #(
    .TICK_W           (TICK_W),
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .SETTLE_TICKS     (SETTLE_TICKS),
    .POLL_TICKS       (POLL_TICKS),
    .MAX_POLLS        (MAX_POLLS),
    .SETPOINT_SCALE   (SETPOINT_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A transfer in holds off the next one until its result is produced.
  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a tick is still in progress");

  // Any reported event ends the scan.
  a_event_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.event_res != EV_NONE)) |-> !out_data.busy_res)
    else $error("event reported while scan still busy");

  // Completion always leaves the clean flag low.
  a_done_clears_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.event_res == EV_DONE)) |-> !out_data.clean_flag)
    else $error("scan done with clean flag high");

  // Setpoint and angle stay consistent.
  a_setpoint_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.setpoint == SP_W'(out_data.angle * SETPOINT_SCALE)))
    else $error("setpoint does not match angle");

endmodule

`default_nettype wire

/* hdl/asq_div.sv */
// ============================================================================
// asq_div
// Serial restoring divider for the scan increment, one quotient bit a cycle.
// ============================================================================
`default_nettype none

module asq_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [asq_pkg::DIFF_W-1:0] dividend,
  input  logic        [asq_pkg::STEP_W-1:0] divisor,
  output logic                              done,
  output logic signed [asq_pkg::INC_W-1:0]  quotient
);
  import asq_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STEP_W-1:0]  rem_r;
  logic [MAG_W-1:0]   dvd_r;
  logic [STEP_W-1:0]  div_r;
  logic               neg_r;

  logic [MAG_W-1:0]   mag;
  logic [STEP_W:0]    trial;
  logic               fits;
  logic [STEP_W-1:0]  rem_nxt;
  logic [MAG_W-1:0]   dvd_nxt;
  logic [INC_W-1:0]   qmag;

  // Magnitude of the dividend; the sign is applied to the quotient at the end.
  assign mag = dividend[DIFF_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial   = {rem_r, dvd_r[MAG_W-1]};
  assign fits    = trial >= {1'b0, div_r};
  assign rem_nxt = fits ? STEP_W'(trial - {1'b0, div_r}) : STEP_W'(trial);
  assign dvd_nxt = {dvd_r[MAG_W-2:0], fits};

  // Quotient truncates toward zero.
  assign qmag     = {1'b0, dvd_r};
  assign quotient = neg_r ? -$signed(qmag) : $signed(qmag);
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= mag;
        div_r  <= divisor;
        neg_r  <= dividend[DIFF_W-1];
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/asq_dp.sv */
// ============================================================================
// asq_dp
// Datapath: configuration, scan state, counters and the result register.
// ============================================================================
`default_nettype none

module asq_dp #(
  parameter int TICK_W           = 19,
  parameter int TICKS_PER_SECOND = 72,
  parameter int SETTLE_TICKS     = 12,
  parameter int POLL_TICKS       = 144,
  parameter int MAX_POLLS        = 120,
  parameter int SETPOINT_SCALE   = 50
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [asq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asq_pkg::CFG_W-1:0]       cfg_data,
  input  asq_pkg::in_item_t               in_data,
  input  asq_pkg::dp_cmd_t                cmd,
  output asq_pkg::dp_status_t             status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output asq_pkg::out_item_t              out_data
);
  import asq_pkg::*;

  // Configuration registers.
  logic [ANG_CFG_W-1:0] start_angle_r;
  logic [ANG_CFG_W-1:0] end_angle_r;
  logic [STEP_W-1:0]    step_count_r;
  logic [DWELL_W-1:0]   dwell_r;

  // Latched tick inputs.
  logic                 start_l_r;
  logic                 abort_l_r;
  logic [RB_W-1:0]      rb_l_r;

  // Scan state.
  phase_t               phase_r;
  logic [STEP_W-1:0]    step_r;
  logic [TICK_W-1:0]    tick_r;
  logic [POLL_W-1:0]    poll_r;
  logic signed [INC_W-1:0] inc_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [SP_W-1:0]      target_r;
  logic [ANGLE_W-1:0]   angle_r;
  logic                 clean_r;
  logic                 strobe_r;
  logic [EV_W-1:0]      ev_r;

  // Result register.
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [STEP_W-1:0]    eff_steps;
  logic [STEP_W-1:0]    divisor;
  logic signed [DIFF_W-1:0] diff;
  logic                 div_done;
  logic signed [INC_W-1:0] quotient;
  logic [ANGLE_W-1:0]   ang_eff;
  logic [SP_W-1:0]      sp_calc;
  logic [TICK_W-1:0]    dwell_ticks;
  logic [TICK_W-1:0]    dwell_load;

  // Step count below two counts as two.
  assign eff_steps = (step_count_r < STEP_W'(2)) ? STEP_W'(2) : step_count_r;
  assign divisor   = eff_steps - STEP_W'(1);
  assign diff      = $signed({end_angle_r[ANG_CFG_W-1], end_angle_r})
                   - $signed({start_angle_r[ANG_CFG_W-1], start_angle_r});

  asq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == DP_DIV),
    .dividend (diff),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Angle of the current step; an angle of zero is moved to one degree.
  assign ang_eff = (acc_r[ANGLE_W-1:0] == '0) ? ANGLE_W'(1) : acc_r[ANGLE_W-1:0];
  assign sp_calc = SP_W'(ang_eff * SETPOINT_SCALE);

  // Dwell length, at least one tick.
  assign dwell_ticks = TICK_W'(dwell_r * TICKS_PER_SECOND);
  assign dwell_load  = (dwell_ticks == '0) ? TICK_W'(1) : dwell_ticks;

  // Status for the controller.
  always_comb begin
    status.start     = start_l_r;
    status.abort     = abort_l_r;
    status.phase     = phase_r;
    status.tick_le1  = tick_r <= TICK_W'(1);
    status.range_bad = (acc_r < 0) || (acc_r > ACC_W'(ANGLE_MAX));
    status.rb_match  = rb_l_r == RB_W'(target_r);
    status.poll_max  = poll_r >= POLL_W'(MAX_POLLS);
    status.step_last = (step_r == '0) || (step_r >= eff_steps);
    status.div_done  = div_done;
    status.out_busy  = out_valid_r && out_stall;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= RST_START_ANGLE;
      end_angle_r   <= RST_END_ANGLE;
      step_count_r  <= RST_STEP_COUNT;
      dwell_r       <= RST_DWELL_SECONDS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_ANGLE:   start_angle_r <= cfg_data[ANG_CFG_W-1:0];
        CFG_END_ANGLE:     end_angle_r   <= cfg_data[ANG_CFG_W-1:0];
        CFG_STEP_COUNT:    step_count_r  <= cfg_data[STEP_W-1:0];
        CFG_DWELL_SECONDS: dwell_r       <= cfg_data[DWELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scan state updates, one operation per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      step_r   <= '0;
      tick_r   <= '0;
      poll_r   <= '0;
      target_r <= '0;
      angle_r  <= '0;
      clean_r  <= 1'b0;
      strobe_r <= 1'b0;
      ev_r     <= EV_NONE;
    end else begin
      case (cmd.op)
        DP_LOAD: begin
          start_l_r <= in_data.start_req;
          abort_l_r <= in_data.abort_req;
          rb_l_r    <= in_data.readback;
          ev_r      <= EV_NONE;
          strobe_r  <= 1'b0;
        end
        DP_DEC: begin
          if (tick_r != '0) begin
            tick_r <= tick_r - 1'b1;
          end
        end
        DP_INIT: begin
          step_r <= '0;
          poll_r <= '0;
          inc_r  <= quotient;
          acc_r  <= ACC_W'($signed(start_angle_r));
        end
        DP_SET_TARGET: begin
          target_r <= sp_calc;
          angle_r  <= ang_eff;
          clean_r  <= 1'b0;
          if (SETTLE_TICKS != 0) begin
            tick_r  <= TICK_W'(SETTLE_TICKS);
            phase_r <= PH_SETTLE;
          end
        end
        DP_ISSUE: begin
          strobe_r <= 1'b1;
          poll_r   <= '0;
        end
        DP_DWELL: begin
          clean_r <= 1'b1;
          tick_r  <= dwell_load;
          phase_r <= PH_DWELL;
        end
        DP_POLL: begin
          poll_r  <= poll_r + 1'b1;
          tick_r  <= TICK_W'(POLL_TICKS);
          phase_r <= PH_POLL;
        end
        DP_NEXT: begin
          step_r <= step_r + 1'b1;
          acc_r  <= acc_r + ACC_W'(inc_r);
        end
        DP_FINISH: begin
          ev_r    <= cmd.ev;
          phase_r <= PH_IDLE;
          tick_r  <= '0;
        end
        DP_DONE: begin
          clean_r <= 1'b0;
          ev_r    <= EV_DONE;
          phase_r <= PH_IDLE;
          tick_r  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: loaded on emit, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r           <= 1'b1;
      out_data_r.clean_flag <= clean_r;
      out_data_r.set_strobe <= strobe_r;
      out_data_r.setpoint   <= target_r;
      out_data_r.angle_mark <= strobe_r;
      out_data_r.angle      <= angle_r;
      out_data_r.busy_res   <= phase_r != PH_IDLE;
      out_data_r.event_res  <= ev_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hdl/asq_ctrl.sv */
// ============================================================================
// asq_ctrl
// Controller: sequences the datapath operations that make up one tick.
// ============================================================================
`default_nettype none

module asq_ctrl #(
  parameter int SETTLE_TICKS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  asq_pkg::dp_status_t  status,
  output asq_pkg::dp_cmd_t     cmd
);
  import asq_pkg::*;

  typedef enum logic [3:0] {
    S_WAIT,
    S_DECODE,
    S_DIV,
    S_BEGIN,
    S_ISSUE,
    S_CHECK,
    S_ENDDWELL,
    S_STEPCHK,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;
  logic   accept;

  assign accept   = in_valid && ready_r;
  assign in_stall = !ready_r;

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    cmd.ev    = EV_NONE;
    case (state_r)
      S_WAIT: begin
        if (accept) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.phase == PH_IDLE) begin
          if (status.start) begin
            cmd.op    = DP_DIV;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          cmd.op = DP_DEC;
          if (status.tick_le1) begin
            case (status.phase)
              PH_SETTLE: state_nxt = S_ISSUE;
              PH_POLL:   state_nxt = S_CHECK;
              default:   state_nxt = S_ENDDWELL;
            endcase
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.op    = DP_INIT;
          state_nxt = S_BEGIN;
        end
      end
      S_BEGIN: begin
        if (status.abort) begin
          cmd.op    = DP_FINISH;
          cmd.ev    = EV_ABORT;
          state_nxt = S_EMIT;
        end else if (status.range_bad) begin
          cmd.op    = DP_FINISH;
          cmd.ev    = EV_RANGE;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = DP_SET_TARGET;
          state_nxt = (SETTLE_TICKS == 0) ? S_ISSUE : S_EMIT;
        end
      end
      S_ISSUE: begin
        cmd.op    = DP_ISSUE;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_EMIT;
        if (status.abort) begin
          cmd.op = DP_FINISH;
          cmd.ev = EV_ABORT;
        end else if (status.rb_match) begin
          cmd.op = DP_DWELL;
        end else if (status.poll_max) begin
          cmd.op = DP_FINISH;
          cmd.ev = EV_TIMEOUT;
        end else begin
          cmd.op = DP_POLL;
        end
      end
      S_ENDDWELL: begin
        cmd.op    = DP_NEXT;
        state_nxt = S_STEPCHK;
      end
      S_STEPCHK: begin
        if (status.step_last) begin
          cmd.op    = DP_DONE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_BEGIN;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op    = DP_EMIT;
          state_nxt = S_WAIT;
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
    ready_nxt = state_nxt == S_WAIT;
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

`default_nettype wire
